### rtl/core/bdc_pkg.sv
package bdc_pkg;

  // Frame layout and byte codes.
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned POS_W             = 4;
  localparam int unsigned PAYLOAD_W         = 64;
  localparam int unsigned CRC_W             = 16;

  localparam logic [7:0]       FLAG_BYTE   = 8'h7E;
  localparam logic [7:0]       ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0]       ESCAPE_XOR  = 8'h20;
  localparam logic [CRC_W-1:0] CRC_POLY    = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT    = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_XOROUT  = 16'hFFFF;

  // One finished frame as it moves to the output register.
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [CRC_W-1:0]     computed_crc;
    logic                 crc_ok;
  } bdc_result_t;

  // CRC-16, MSB first, one byte folded in over eight shift steps.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0]       data);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### rtl/core/byte_deframer_crc16_checker_core.sv
// Byte deframer with CRC-16 check.
//
// Input channel in_*: one raw serial byte per word in in_tdata. An unescaped
// 0x7E restarts the frame, 0x7D escapes the next byte (XOR 0x20). Decoded
// bytes form a frame of PAYLOAD_BYTES payload bytes followed by the received
// CRC, low byte first.
// Output channel out_*: one word per completed frame with the payload, the
// locally computed CRC-16 (poly 0x1021, init and final XOR 0xFFFF) and a
// match flag in out_tuser.
// The input register holds each accepted byte; the result of a byte that closes
// a frame is then registered in the output register.
// Throughput: one byte per cycle, set by the single input register and the
// CRC byte update, while the output register can take each closing byte.
// Reset clears the escape flag, the frame position, the CRC and both valid
// registers; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and bytes
// that close no frame keep flowing; a byte that closes a frame waits in the
// input register until the output register frees up.
module byte_deframer_crc16_checker_core #(
  parameter int unsigned PAYLOAD_BYTES = bdc_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [63:0] payload, [79:64] computed_crc
  output logic        out_tuser   // [0] crc_ok
);

  logic                 res_vld;
  logic                 res_rdy;
  bdc_pkg::bdc_result_t res;
  bdc_pkg::bdc_result_t out_res;

  bdc_frame_proc #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_proc (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_byte  (in_tdata),
    .res_vld  (res_vld),
    .res_rdy  (res_rdy),
    .res      (res)
  );

  bdc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res       (res),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_res   (out_res)
  );

  // Pack the result word.
  assign out_tdata = {out_res.computed_crc, out_res.payload};
  assign out_tuser = out_res.crc_ok;

endmodule

### rtl/core/bdc_frame_proc.sv
module bdc_frame_proc #(
  parameter int unsigned PAYLOAD_BYTES = bdc_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_byte,
  output logic                res_vld,
  input  logic                res_rdy,
  output bdc_pkg::bdc_result_t res
);

  localparam logic [bdc_pkg::POS_W-1:0] LAST_PAY = bdc_pkg::POS_W'(PAYLOAD_BYTES);

  logic                         in_vld_r;
  logic [7:0]                   in_byte_r;
  logic                         esc_r;
  logic [bdc_pkg::POS_W-1:0]    pos_r;
  logic [bdc_pkg::CRC_W-1:0]    crc_r;
  logic [bdc_pkg::PAYLOAD_W-1:0] payload_r;
  logic [7:0]                   crc_lo_r;

  logic                         is_data;
  logic                         is_flag;
  logic                         is_esc;
  logic [7:0]                   data_byte;
  logic                         in_payload;
  logic                         in_crc_lo;
  logic                         produces;
  logic                         advance;
  logic [bdc_pkg::CRC_W-1:0]    computed;

  // Decode the registered byte: escaped data, flag, escape marker or plain data.
  always_comb begin
    data_byte  = esc_r ? (in_byte_r ^ bdc_pkg::ESCAPE_XOR) : in_byte_r;
    is_flag    = !esc_r && (in_byte_r == bdc_pkg::FLAG_BYTE);
    is_esc     = !esc_r && (in_byte_r == bdc_pkg::ESCAPE_BYTE);
    is_data    = !is_flag && !is_esc;
    in_payload = pos_r < LAST_PAY;
    in_crc_lo  = pos_r == LAST_PAY;
    produces   = is_data && !in_payload && !in_crc_lo;
    advance    = in_vld_r && (!produces || res_rdy);
    in_tready  = !in_vld_r || advance;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_byte;
    end
  end

  // Frame control state: escape flag, position and running CRC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      pos_r <= '0;
      crc_r <= bdc_pkg::CRC_INIT;
    end else if (advance) begin
      esc_r <= is_esc;
      if (is_flag || produces) begin
        pos_r <= '0;
        crc_r <= bdc_pkg::CRC_INIT;
      end else if (is_data) begin
        pos_r <= pos_r + 1'b1;
        if (in_payload) begin
          crc_r <= bdc_pkg::crc_byte(crc_r, data_byte);
        end
      end
    end
  end

  // Payload and received CRC low byte; the first payload byte clears the rest.
  always_ff @(posedge clk) begin
    if (advance && is_data) begin
      if (in_payload) begin
        if (pos_r == '0) begin
          payload_r <= {{(bdc_pkg::PAYLOAD_W-8){1'b0}}, data_byte};
        end else begin
          payload_r[pos_r[2:0]*8 +: 8] <= data_byte;
        end
      end else if (in_crc_lo) begin
        crc_lo_r <= data_byte;
      end
    end
  end

  // Result of the frame closed by the current byte.
  always_comb begin
    computed         = crc_r ^ bdc_pkg::CRC_XOROUT;
    res_vld          = in_vld_r && produces;
    res.payload      = payload_r;
    res.computed_crc = computed;
    res.crc_ok       = (crc_lo_r == computed[7:0]) && (data_byte == computed[15:8]);
  end

endmodule

### rtl/core/bdc_out_reg.sv
module bdc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_vld,
  output logic                 res_rdy,
  input  bdc_pkg::bdc_result_t res,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output bdc_pkg::bdc_result_t out_res
);

  logic                 vld_r;
  bdc_pkg::bdc_result_t data_r;

  // The register takes a new word when empty or when its word leaves this cycle.
  assign res_rdy    = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_res    = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_rdy) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && res_vld) begin
      data_r <= res;
    end
  end

endmodule

### rtl/core/bdc_checker.sv
module bdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tuser
);

  // A stalled word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // A stalled word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A result appearing on an idle output comes from a byte taken through the input register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input byte");

endmodule

bind byte_deframer_crc16_checker_core bdc_checker u_bdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
